// ===== rtl/bspl_pkg.sv =====
package bspl_pkg;

    localparam int MAX_NODES_DEF  = 4096;
    localparam int MAX_WALK_DEF   = 64;

    localparam int COORD_W = 32;
    localparam int LINK_W  = 16;
    localparam int SUB_W   = 15;
    localparam int CNT_W   = 13;
    localparam int IDX_W   = 12;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_LOCATE = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic        [LINK_W-1:0]  front_link;
        logic        [LINK_W-1:0]  back_link;
    } node_t;

    typedef struct packed {
        logic done;
        logic back;
    } side_res_t;

endpackage

// ===== rtl/bspl_node_ram.sv =====
module bspl_node_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic            aclk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  bspl_pkg::node_t wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output bspl_pkg::node_t rd_data
);
    import bspl_pkg::*;

    node_t mem [DEPTH];
    node_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/bspl_index_reduce.sv =====
module bspl_index_reduce #(
    parameter int MAX_NODES = 4096,
    parameter int AW        = 12
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [14:0]   value,
    output logic          done,
    output logic [AW-1:0] result
);
    import bspl_pkg::*;

    localparam bit POW2 = (MAX_NODES > 1) && ((MAX_NODES & (MAX_NODES - 1)) == 0);

    logic          done_reg;
    logic [AW-1:0] result_reg;

    generate
        if (POW2) begin : g_mask
            // power-of-two depth: the low bits are the remainder
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    done_reg <= 1'b0;
                end else begin
                    done_reg <= start;
                end
                if (start) begin
                    result_reg <= value[AW-1:0];
                end
            end
        end else begin : g_restore
            // restoring reduction, four conditional subtracts per cycle
            localparam int DW       = 32;
            localparam int RS       = 16;
            localparam logic [DW-1:0] DIV_INIT = DW'(MAX_NODES) << (RS - 1);

            logic          busy_reg;
            logic [1:0]    cnt_reg;
            logic [14:0]   val_reg;
            logic [DW-1:0] div_reg;
            logic [14:0]   val_next;
            logic [DW-1:0] div_next;

            always_comb begin
                logic [14:0]   v;
                logic [DW-1:0] d;
                v = val_reg;
                d = div_reg;
                for (int j = 0; j < 4; j++) begin
                    if (DW'(v) >= d) begin
                        v = v - d[14:0];
                    end
                    d = d >> 1;
                end
                val_next = v;
                div_next = d;
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b0;
                    cnt_reg  <= '0;
                end else begin
                    done_reg <= 1'b0;
                    if (start) begin
                        busy_reg <= 1'b1;
                        cnt_reg  <= '0;
                    end else if (busy_reg) begin
                        cnt_reg <= cnt_reg + 2'd1;
                        if (cnt_reg == 2'd3) begin
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end
                    end
                end
                if (start) begin
                    val_reg <= value;
                    div_reg <= DIV_INIT;
                end else if (busy_reg) begin
                    val_reg <= val_next;
                    div_reg <= div_next;
                    if (cnt_reg == 2'd3) begin
                        result_reg <= val_next[AW-1:0];
                    end
                end
            end
        end
    endgenerate

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/bspl_side_test.sv =====
module bspl_side_test (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    start,
    input  logic signed [bspl_pkg::COORD_W-1:0]     point_x,
    input  logic signed [bspl_pkg::COORD_W-1:0]     point_y,
    input  bspl_pkg::node_t                         node,
    output bspl_pkg::side_res_t                     res
);
    import bspl_pkg::*;

    // stage 1: offsets, exact cases and sign shortcut
    logic signed [COORD_W-1:0] rx, ry;
    logic                      early, early_side;

    always_comb begin
        rx = point_x - node.origin_x;
        ry = point_y - node.origin_y;
        early      = 1'b1;
        early_side = 1'b0;
        if (node.dir_x == '0) begin
            if (point_x <= node.origin_x) begin
                early_side = node.dir_y > 0;
            end else begin
                early_side = node.dir_y < 0;
            end
        end else if (node.dir_y == '0) begin
            if (point_y <= node.origin_y) begin
                early_side = node.dir_x < 0;
            end else begin
                early_side = node.dir_x > 0;
            end
        end else if (node.dir_y[31] ^ node.dir_x[31] ^ rx[31] ^ ry[31]) begin
            early_side = node.dir_y[31] ^ rx[31];
        end else begin
            early = 1'b0;
        end
    end

    logic                      v1_reg, v2_reg, done_reg;
    logic                      e1_reg, es1_reg, e2_reg, es2_reg, side_reg;
    logic signed [COORD_W-1:0] rx_reg, ry_reg;
    logic signed [15:0]        dxh_reg, dyh_reg;
    logic signed [47:0]        pl_reg, pr_reg;
    logic signed [47:0]        pl_next, pr_next;

    assign pl_next = ry_reg * dxh_reg;
    assign pr_next = dyh_reg * rx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
        if (start) begin
            e1_reg  <= early;
            es1_reg <= early_side;
            rx_reg  <= rx;
            ry_reg  <= ry;
            dxh_reg <= node.dir_x[31:16];
            dyh_reg <= node.dir_y[31:16];
        end
        if (v1_reg) begin
            e2_reg  <= e1_reg;
            es2_reg <= es1_reg;
            pl_reg  <= pl_next;
            pr_reg  <= pr_next;
        end
        if (v2_reg) begin
            // the shift by 16 of each product is the top 32 bits
            side_reg <= e2_reg ? es2_reg
                               : ($signed(pl_reg[47:16]) >= $signed(pr_reg[47:16]));
        end
    end

    assign res.done = done_reg;
    assign res.back = side_reg;

endmodule

// ===== rtl/bsp_point_locate.sv =====
// channel   direction  handshake          payload
// s_        in         s_valid / s_ready  func, node_index, part_*, child_*, point_*
// m_        out        m_valid / m_ready  subsector_index, walk_overflow
// cfg_      in         cfg_we             cfg_wdata = node_count
//
// a node write passes the index reduction (masking for a power-of-two MAX_NODES,
// restoring otherwise) ahead of the single node memory write port
// a locate walks down from the root node; per level it takes one check, the index
// reduction, one memory read and a 3-stage side test
// reset clears control state only; the node memory is not cleared
// a result waiting on m_ready holds back the end of the next transaction only
module bsp_point_locate #(
    parameter int MAX_NODES      = bspl_pkg::MAX_NODES_DEF,
    parameter int MAX_WALK_STEPS = bspl_pkg::MAX_WALK_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [bspl_pkg::CNT_W-1:0]          cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_func,
    input  logic [bspl_pkg::IDX_W-1:0]          s_node_index,
    input  logic signed [bspl_pkg::COORD_W-1:0] s_part_x,
    input  logic signed [bspl_pkg::COORD_W-1:0] s_part_y,
    input  logic signed [bspl_pkg::COORD_W-1:0] s_part_dx,
    input  logic signed [bspl_pkg::COORD_W-1:0] s_part_dy,
    input  logic [bspl_pkg::LINK_W-1:0]         s_child_front,
    input  logic [bspl_pkg::LINK_W-1:0]         s_child_back,
    input  logic signed [bspl_pkg::COORD_W-1:0] s_point_x,
    input  logic signed [bspl_pkg::COORD_W-1:0] s_point_y,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [bspl_pkg::SUB_W-1:0]          m_subsector_index,
    output logic                                m_walk_overflow
);
    import bspl_pkg::*;

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int SW = $clog2(MAX_WALK_STEPS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRED,   // write index reduction
        ST_CHECK,  // leaf or step limit test on the current link
        ST_RED,    // link index reduction, then memory read
        ST_TEST,   // memory data valid, start side test
        ST_WAIT,   // side test in flight
        ST_DONE    // result waits for the output register
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]         node_count_reg, node_count_next;
    logic [LINK_W-1:0]        link_reg, link_next;
    logic [SW-1:0]            steps_reg, steps_next;
    logic [SUB_W-1:0]         res_sub_reg, res_sub_next;
    logic                     res_ovf_reg, res_ovf_next;
    logic                     m_valid_reg, m_valid_next;
    logic [SUB_W-1:0]         m_sub_reg, m_sub_next;
    logic                     m_ovf_reg, m_ovf_next;
    node_t                    wnode_reg;
    logic signed [COORD_W-1:0] px_reg, py_reg;

    logic                     s_fire;
    logic                     red_start, red_done;
    logic [14:0]              red_value;
    logic [AW-1:0]            red_result;
    logic                     ram_wr_en, ram_rd_en;
    node_t                    ram_rd_data;
    logic                     side_start;
    side_res_t                side_res;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    // next-state and datapath control
    always_comb begin
        state_next      = state_reg;
        node_count_next = cfg_we ? cfg_wdata : node_count_reg;
        link_next       = link_reg;
        steps_next      = steps_reg;
        res_sub_next    = res_sub_reg;
        res_ovf_next    = res_ovf_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_sub_next      = m_sub_reg;
        m_ovf_next      = m_ovf_reg;
        red_start       = 1'b0;
        red_value       = link_reg[14:0];
        ram_wr_en       = 1'b0;
        ram_rd_en       = 1'b0;
        side_start      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                red_value = 15'(s_node_index);
                if (s_fire) begin
                    res_sub_next = '0;
                    res_ovf_next = 1'b0;
                    steps_next   = '0;
                    // root is the last loaded node
                    link_next    = LINK_W'(node_count_reg - CNT_W'(1));
                    if (s_func == FUNC_WRITE) begin
                        red_start  = 1'b1;
                        state_next = ST_WRED;
                    end else if (node_count_reg == '0) begin
                        // empty tree answers subsector 0
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_WRED: begin
                if (red_done) begin
                    ram_wr_en  = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_CHECK: begin
                if (link_reg[LINK_W-1]) begin
                    res_sub_next = link_reg[SUB_W-1:0];
                    state_next   = ST_DONE;
                end else if (steps_reg == SW'(MAX_WALK_STEPS)) begin
                    res_ovf_next = 1'b1;
                    state_next   = ST_DONE;
                end else begin
                    red_start  = 1'b1;
                    state_next = ST_RED;
                end
            end
            ST_RED: begin
                if (red_done) begin
                    ram_rd_en  = 1'b1;
                    state_next = ST_TEST;
                end
            end
            ST_TEST: begin
                side_start = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (side_res.done) begin
                    link_next  = side_res.back ? ram_rd_data.back_link
                                               : ram_rd_data.front_link;
                    steps_next = steps_reg + SW'(1);
                    state_next = ST_CHECK;
                end
            end
            ST_DONE: begin
                // output register free or draining this cycle
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_sub_next   = res_sub_reg;
                    m_ovf_next   = res_ovf_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            node_count_reg <= '0;
            m_valid_reg    <= 1'b0;
            steps_reg      <= '0;
        end else begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            m_valid_reg    <= m_valid_next;
            steps_reg      <= steps_next;
        end
        link_reg    <= link_next;
        res_sub_reg <= res_sub_next;
        res_ovf_reg <= res_ovf_next;
        m_sub_reg   <= m_sub_next;
        m_ovf_reg   <= m_ovf_next;
        if (s_fire) begin
            wnode_reg.origin_x   <= s_part_x;
            wnode_reg.origin_y   <= s_part_y;
            wnode_reg.dir_x      <= s_part_dx;
            wnode_reg.dir_y      <= s_part_dy;
            wnode_reg.front_link <= s_child_front;
            wnode_reg.back_link  <= s_child_back;
            px_reg               <= s_point_x;
            py_reg               <= s_point_y;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_subsector_index = m_sub_reg;
    assign m_walk_overflow   = m_ovf_reg;

    // node index modulo the table depth
    bspl_index_reduce #(
        .MAX_NODES (MAX_NODES),
        .AW        (AW)
    ) u_reduce (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (red_start),
        .value   (red_value),
        .done    (red_done),
        .result  (red_result)
    );

    // node table, one write and one registered read port
    bspl_node_ram #(
        .DEPTH (MAX_NODES),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (red_result),
        .wr_data (wnode_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (red_result),
        .rd_data (ram_rd_data)
    );

    // which side of the partition line the point lies on
    bspl_side_test u_side (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (side_start),
        .point_x (px_reg),
        .point_y (py_reg),
        .node    (ram_rd_data),
        .res     (side_res)
    );

    // a walk never reads more nodes than the limit
    a_steps_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        steps_reg <= SW'(MAX_WALK_STEPS))
        else $error("walk step counter past limit");

    // side test results only arrive while the walk waits for them
    a_side_when_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        side_res.done |-> state_reg == ST_WAIT)
        else $error("side test result outside wait state");

    // index reduction completes only where its result is consumed
    a_reduce_when_used: assert property (@(posedge aclk) disable iff (!aresetn)
        red_done |-> (state_reg == ST_WRED || state_reg == ST_RED))
        else $error("index reduction done in wrong state");

    // an overflowed walk reports subsector 0
    a_ovf_sub_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && res_ovf_reg) |-> res_sub_reg == '0)
        else $error("overflow result with nonzero subsector");

endmodule
